/* hw/rtl/sat_pkg.sv */
// Shared types and constants for the section address translator.
// Used by sat_engine and section_address_translator_unit; no dependencies.
package sat_pkg;

	localparam int MAX_SECTIONS_DEF = 16;

	localparam int ADDR_W   = 32;
	localparam int IDX_IN_W = 4;
	localparam int MODE_W   = 2;
	localparam int STAT_W   = 2;
	localparam int COUNT_W  = 5;
	localparam int CFG_IX_W = 2;

	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_M2F   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_F2M   = 2'd2;

	localparam logic [STAT_W-1:0] STAT_IDENTITY = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FOUND    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_MISSING  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_WRITTEN  = 2'd3;

	localparam logic [CFG_IX_W-1:0] CFG_HEADER_SIZE  = 2'd0;
	localparam logic [CFG_IX_W-1:0] CFG_MEM_ALIGN    = 2'd1;
	localparam logic [CFG_IX_W-1:0] CFG_FILE_ALIGN   = 2'd2;
	localparam logic [CFG_IX_W-1:0] CFG_SECTION_CNT  = 2'd3;

	localparam logic [ADDR_W-1:0] MEM_ALIGN_RST  = 32'd4096;
	localparam logic [ADDR_W-1:0] FILE_ALIGN_RST = 32'd512;

	typedef struct packed {
		logic [ADDR_W-1:0] file_size;
		logic [ADDR_W-1:0] file_start;
		logic [ADDR_W-1:0] mem_size;
		logic [ADDR_W-1:0] mem_start;
	} sat_entry_t;

	localparam int ENTRY_W = $bits(sat_entry_t);

	typedef struct packed {
		logic [ADDR_W-1:0]  header_size;
		logic [ADDR_W-1:0]  mem_align;
		logic [ADDR_W-1:0]  file_align;
		logic [COUNT_W-1:0] section_count;
	} sat_cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [STAT_W-1:0] status;
	} sat_result_t;

endpackage

/* hw/rtl/sat_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/sat_engine.sv */
// Translation sequencer: writes section entries and walks the section RAM in order.
// Depends on sat_pkg; drives the ports of one sat_ram instance.
module sat_engine
	import sat_pkg::*;
#(
	parameter int MAX_SECTIONS = MAX_SECTIONS_DEF,
	parameter int AW    = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1,
	parameter int IDX_W = $clog2(MAX_SECTIONS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sat_cfg_t            cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [MODE_W-1:0]   in_mode,
	input  logic [IDX_IN_W-1:0] in_idx,
	input  sat_entry_t          in_entry,
	input  logic [ADDR_W-1:0]   in_addr,
	output logic                ram_we,
	output logic [AW-1:0]       ram_waddr,
	output sat_entry_t          ram_wdata,
	output logic                ram_re,
	output logic [AW-1:0]       ram_raddr,
	input  sat_entry_t          ram_rdata,
	output logic                res_valid,
	input  logic                res_ready,
	output sat_result_t         res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_REBASE,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [MODE_W-1:0] mode_q;
	logic [ADDR_W-1:0] addr_q;
	logic [IDX_W-1:0]  limit_q;
	logic [IDX_W-1:0]  rd_ptr_q;
	logic              rvld_s1;
	logic [ADDR_W-1:0] lo_q;
	logic [ADDR_W-1:0] dst_q;
	sat_result_t       res_q;

	logic              accept;
	logic              identity;
	logic [IDX_W-1:0]  limit;
	logic              issue;
	logic [ADDR_W-1:0] lo;
	logic [ADDR_W-1:0] size;
	logic [ADDR_W-1:0] hi;
	logic [ADDR_W-1:0] dst;
	logic              hit;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign identity = (in_addr < cfg.header_size) || (cfg.mem_align == cfg.file_align);
	assign limit    = (32'(cfg.section_count) > MAX_SECTIONS) ? IDX_W'(MAX_SECTIONS)
	                                                          : IDX_W'(cfg.section_count);

	assign ram_we    = accept && (in_mode == MODE_WRITE) && (32'(in_idx) < MAX_SECTIONS);
	assign ram_waddr = AW'(in_idx);
	assign ram_wdata = in_entry;

	assign issue     = (state_q == S_SEARCH) && (rd_ptr_q < limit_q);
	assign ram_re    = issue;
	assign ram_raddr = rd_ptr_q[AW-1:0];

	always_comb begin
		if (mode_q == MODE_M2F) begin
			lo   = ram_rdata.mem_start;
			size = ram_rdata.mem_size;
			dst  = ram_rdata.file_start;
		end else begin
			lo   = ram_rdata.file_start;
			size = ram_rdata.file_size;
			dst  = ram_rdata.mem_start;
		end
		hi  = lo + size;
		hit = rvld_s1 && (addr_q >= lo) && (addr_q < hi);
	end

	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rvld_s1  <= 1'b0;
			rd_ptr_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					rvld_s1  <= 1'b0;
					rd_ptr_q <= '0;
					if (accept) begin
						mode_q  <= in_mode;
						addr_q  <= in_addr;
						limit_q <= limit;
						if (in_mode == MODE_WRITE) begin
							res_q   <= '{addr: '0, status: STAT_WRITTEN};
							state_q <= S_DONE;
						end else if (in_mode != MODE_M2F && in_mode != MODE_F2M) begin
							res_q   <= '{addr: '0, status: STAT_MISSING};
							state_q <= S_DONE;
						end else if (identity) begin
							res_q   <= '{addr: in_addr, status: STAT_IDENTITY};
							state_q <= S_DONE;
						end else if (limit == '0) begin
							res_q   <= '{addr: '0, status: STAT_MISSING};
							state_q <= S_DONE;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					rvld_s1 <= issue;
					if (issue) begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
					end
					if (hit) begin
						lo_q    <= lo;
						dst_q   <= dst;
						state_q <= S_REBASE;
					end else if (rvld_s1 && !issue) begin
						res_q   <= '{addr: '0, status: STAT_MISSING};
						state_q <= S_DONE;
					end
				end
				S_REBASE: begin
					rvld_s1 <= 1'b0;
					res_q   <= '{addr: addr_q - lo_q + dst_q, status: STAT_FOUND};
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/section_address_translator_unit.sv */
// Section address translator top level: config registers, section RAM, sequencer, output stage.
// Depends on sat_pkg, sat_ram and sat_engine.
// Write, identity and out-of-range items skip the search and pass from the result register to the output register;
// a search reads up to min(section_count, MAX_SECTIONS) entries, one RAM read per cycle.
// Throughput: one item at a time; the next item is taken while a result waits in the output register.
// Reset: asynchronous reset of control state and config registers; section RAM is not cleared.
module section_address_translator_unit
	import sat_pkg::*;
#(
	parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_IX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]   cfg_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	// entry_index, entry_mem_start, entry_mem_size, entry_file_start,
	// entry_file_size, query_address, zero fill
	input  logic [167:0]        s_tdata,
	// mode
	input  logic [MODE_W-1:0]   s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// translated_address
	output logic [ADDR_W-1:0]   m_tdata,
	// status
	output logic [STAT_W-1:0]   m_tuser
);

	localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

	sat_cfg_t          cfg_q;
	logic              m_tvalid_q;
	logic [ADDR_W-1:0] m_tdata_q;
	logic [STAT_W-1:0] m_tuser_q;

	sat_entry_t        in_entry;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	sat_entry_t        ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	sat_entry_t        ram_rdata;
	logic              res_valid;
	logic              res_ready;
	sat_result_t       res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_size   <= '0;
			cfg_q.mem_align     <= MEM_ALIGN_RST;
			cfg_q.file_align    <= FILE_ALIGN_RST;
			cfg_q.section_count <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEADER_SIZE: cfg_q.header_size   <= cfg_data;
				CFG_MEM_ALIGN:   cfg_q.mem_align     <= cfg_data;
				CFG_FILE_ALIGN:  cfg_q.file_align    <= cfg_data;
				CFG_SECTION_CNT: cfg_q.section_count <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_entry.mem_start  = s_tdata[35:4];
	assign in_entry.mem_size   = s_tdata[67:36];
	assign in_entry.file_start = s_tdata[99:68];
	assign in_entry.file_size  = s_tdata[131:100];

	sat_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_SECTIONS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sat_engine #(
		.MAX_SECTIONS (MAX_SECTIONS),
		.AW           (AW)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser),
		.in_idx    (s_tdata[3:0]),
		.in_entry  (in_entry),
		.in_addr   (s_tdata[163:132]),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register: load when empty or when the held transfer completes
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_tdata_q <= res.addr;
			m_tuser_q <= res.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
